>>> hdl/rtfa_pkg.sv
// rtfa_pkg: shared types, constants and rounding helpers for the
// continued-fraction approximator. No dependencies.
`default_nettype none
package rtfa_pkg;

  // Unbiased binary exponent with room for subnormal and overflow range.
  typedef logic signed [12:0] exp_t;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_ITER, S_FRAC, S_MULN, S_MULD, S_CVTN, S_CVTD,
    S_DIVQ, S_SUB, S_SUBN, S_CMP, S_REM, S_RECIP, S_DONE
  } state_t;

  typedef struct packed {
    logic        carry;
    logic [52:0] mant;
  } rnd_t;

  localparam logic [62:0] TOL_RESET = 63'h3EB0C6F7A0B5ED8D;
  localparam logic [10:0] EXP_ALL   = 11'h7FF;
  localparam exp_t        EXP_BIAS  = 13'sd1023;
  localparam exp_t        EXP_MAX   = 13'sd1023;
  localparam logic [52:0] MANT_ONE  = 53'h10_0000_0000_0000;

  // Round a word normalized to bit 63 down to 53 bits, nearest even.
  function automatic rnd_t round_w(logic [63:0] w);
    rnd_t        r;
    logic        up;
    logic [53:0] sum;
    up  = w[10] && ((|w[9:0]) || w[11]);
    sum = {1'b0, w[63:11]} + {53'd0, up};
    r.carry = sum[53];
    r.mant  = sum[53] ? sum[53:1] : sum[52:0];
    return r;
  endfunction

  // Bits of a positive normal double, sign bit dropped.
  function automatic logic [62:0] pack_pos(logic [52:0] m, exp_t e);
    exp_t be;
    be = e + EXP_BIAS;
    return {be[10:0], m[51:0]};
  endfunction

endpackage
`default_nettype wire

>>> hdl/rtfa_norm.sv
// rtfa_norm: shift-left normalizer, one bit per cycle until bit 63 is set or the word is zero.
// Depends on rtfa_pkg.
`default_nettype none
module rtfa_norm (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic [63:0]   w_in,
  input  rtfa_pkg::exp_t     e_in,
  output logic [63:0]        w,
  output rtfa_pkg::exp_t     e,
  output logic               done
);
  import rtfa_pkg::*;

  assign done = w[63] || (w == 64'd0);

  always_ff @(posedge clk) begin
    if (load) begin
      w <= w_in;
      e <= e_in;
    end else if (!done) begin
      w <= {w[62:0], 1'b0};
      e <= e - 13'sd1;
    end
  end

endmodule
`default_nettype wire

>>> hdl/rtfa_mul.sv
// rtfa_mul: bit-serial add + s*m on 64-bit unsigned values with wrap flag.
// Depends on rtfa_pkg (import only for house consistency of types).
`default_nettype none
module rtfa_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] s,
  input  wire logic [63:0] m,
  input  wire logic [63:0] add,
  output logic [63:0]      res,
  output logic             ovf,
  output logic             done
);
  import rtfa_pkg::*;

  logic [63:0] s_sh, m_r, add_r, acc;
  logic        ovf_acc, run;
  logic [6:0]  cnt;
  logic [64:0] step_sum, fin_sum;

  assign step_sum = {1'b0, acc[62:0], 1'b0} + {1'b0, (s_sh[63] ? m_r : 64'd0)};
  assign fin_sum  = {1'b0, acc} + {1'b0, add_r};
  assign res      = fin_sum[63:0];
  assign ovf      = ovf_acc || fin_sum[64];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= run && (cnt == 7'd1);
      if (start) begin
        run <= 1'b1;
        cnt <= 7'd64;
      end else if (run) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) run <= 1'b0;
      end
    end
  end

  // MSB-first shift-add; any bit pushed past bit 63 means a wrap
  always_ff @(posedge clk) begin
    if (start) begin
      s_sh    <= s;
      m_r     <= m;
      add_r   <= add;
      acc     <= 64'd0;
      ovf_acc <= 1'b0;
    end else if (run) begin
      s_sh    <= {s_sh[62:0], 1'b0};
      acc     <= step_sum[63:0];
      ovf_acc <= ovf_acc || acc[63] || step_sum[64];
    end
  end

endmodule
`default_nettype wire

>>> hdl/rtfa_div.sv
// rtfa_div: restoring mantissa divider, one quotient bit per cycle,
// round to nearest even. Depends on rtfa_pkg.
`default_nettype none
module rtfa_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [52:0] ma,
  input  rtfa_pkg::exp_t   ea,
  input  wire logic [52:0] mb,
  input  rtfa_pkg::exp_t   eb,
  output logic [52:0]      mant,
  output rtfa_pkg::exp_t   e,
  output logic             done
);
  import rtfa_pkg::*;

  logic [54:0] r;
  logic [53:0] q;
  logic [52:0] mb_r;
  exp_t        e_r;
  logic        run, ge;
  logic [5:0]  cnt;
  logic [54:0] r_sub;
  rnd_t        rnd;

  assign ge    = r >= {2'b00, mb_r};
  assign r_sub = ge ? (r - {2'b00, mb_r}) : r;
  assign rnd   = round_w({q, 9'd0, (r != 55'd0)});
  assign mant  = rnd.mant;
  assign e     = e_r + exp_t'(rnd.carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= run && (cnt == 6'd1);
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd54;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mb_r <= mb;
      q    <= 54'd0;
      if (ma < mb) begin
        r   <= {1'b0, ma, 1'b0};
        e_r <= ea - eb - 13'sd1;
      end else begin
        r   <= {2'b00, ma};
        e_r <= ea - eb;
      end
    end else if (run) begin
      r <= {r_sub[53:0], 1'b0};
      q <= {q[52:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> hdl/real_to_fraction_approximator_core.sv
// real_to_fraction_approximator_core: top level, sequencer and datapath regs.
// Depends on rtfa_pkg, rtfa_norm, rtfa_mul, rtfa_div.
//
// Usage: pulse start with value_bits (IEEE double) while busy is low; the item
// is taken on that edge and busy stays high until the result goes out. The
// result (numerator, denominator, status) is valid for exactly one cycle with
// done high; the receiver cannot stall it. tolerance_bits is written when
// cfg_we is high; the user must do so only while busy is low, as the block
// itself does not enforce it. The value's magnitude is expanded as a
// continued fraction; each term runs through a shared normalizer
// (1 bit/cycle), a bit-serial 64-bit multiplier (used twice) and a restoring
// divider (used for the error quotient and the reciprocal). The time per
// term is set mostly by those serial units; the number of terms is at most
// MAX_ITERATIONS. NaN or infinite inputs go from idle straight to the done
// state. Reset returns to idle and loads the default tolerance of one
// millionth.
`default_nettype none
module real_to_fraction_approximator_core #(
  parameter int MAX_ITERATIONS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [63:0]        value_bits,
  input  wire logic               cfg_we,
  input  wire logic [62:0]        tolerance_bits,
  output logic                    done,
  output logic signed [63:0]      numerator,
  output logic [63:0]             denominator,
  output rtfa_pkg::status_t       status
);
  import rtfa_pkg::*;

  localparam int IW = $clog2(MAX_ITERATIONS + 1);

  state_t state, state_next;
  logic [62:0] tol;

  // datapath registers
  logic [63:0] vb;
  logic        neg, vzero;
  logic [52:0] vm, g_m, rm, nm, dm, qm;
  exp_t        ve, g_e, re, ne, de, qe;
  logic        g_zero, g_inf, rzero;
  logic [63:0] a, b, c, d, s, num, den;
  logic [62:0] errb;
  logic [IW-1:0] iter;
  logic        dec_loaded;

  // unit handshakes
  logic        norm_load, norm_done;
  logic [63:0] norm_w_in, norm_w;
  exp_t        norm_e_in, norm_e;
  logic        mul_start, mul_ovf, mul_done;
  logic [63:0] mul_s, mul_m, mul_add, mul_res;
  logic        div_start, div_done;
  logic [52:0] div_ma, div_mb, div_mant;
  exp_t        div_ea, div_eb, div_e;

  logic        fin;
  status_t     fin_status;
  logic [63:0] fin_num, fin_den;

  rtfa_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .s(mul_s), .m(mul_m),
    .add(mul_add), .res(mul_res), .ovf(mul_ovf), .done(mul_done)
  );

  rtfa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .ma(div_ma), .ea(div_ea),
    .mb(div_mb), .eb(div_eb), .mant(div_mant), .e(div_e), .done(div_done)
  );

  // ---- combinational helpers ----
  logic        in_bad, g_bad, accept, tol_nan;
  logic [63:0] s_calc;
  logic [52:0] frac_calc;
  logic [5:0]  shl, shr;
  rnd_t        nrnd;
  exp_t        nrnd_e;
  logic [63:0] dec_w;
  exp_t        dec_e;

  assign in_bad  = value_bits[62:52] == EXP_ALL;
  assign g_bad   = g_inf || (!g_zero && (g_e >= 13'sd64));
  assign tol_nan = (tol[62:52] == EXP_ALL) && (tol[51:0] != 52'd0);
  assign accept  = !tol_nan && (tol > errb);
  assign nrnd    = round_w(norm_w);
  assign nrnd_e  = norm_e + exp_t'(nrnd.carry);
  assign shl     = 6'(g_e - 13'sd52);
  assign shr     = 6'(13'sd52 - g_e);

  // subnormals enter with the minimum exponent and get normalized
  always_comb begin
    if (vb[62:52] == 11'd0) begin
      dec_w = {1'b0, vb[51:0], 11'd0};
      dec_e = -13'sd1022;
    end else begin
      dec_w = {1'b1, vb[51:0], 11'd0};
      dec_e = exp_t'({2'b00, vb[62:52]}) - EXP_BIAS;
    end
  end

  // integer part and fraction of g
  always_comb begin
    if (g_zero || (g_e < 13'sd0)) begin
      s_calc    = 64'd0;
      frac_calc = g_zero ? 53'd0 : g_m;
    end else if (g_e >= 13'sd52) begin
      s_calc    = {11'd0, g_m} << shl;
      frac_calc = 53'd0;
    end else begin
      s_calc    = {11'd0, g_m} >> shr;
      frac_calc = g_m & ((53'd1 << shr) - 53'd1);
    end
  end

  // aligned magnitude difference |q - |v|| with guard, round and sticky
  logic        q_big;
  logic [52:0] bm, sm;
  exp_t        be, se, dexp;
  logic [111:0] ywide;
  logic [55:0] y, diff;

  always_comb begin
    q_big = (qe > ve) || ((qe == ve) && (qm >= vm));
    bm    = q_big ? qm : vm;
    be    = q_big ? qe : ve;
    sm    = q_big ? vm : qm;
    se    = q_big ? ve : qe;
    dexp  = be - se;
    ywide = {sm, 3'd0, 56'd0} >> dexp[5:0];
    if (dexp >= 13'sd56) y = 56'd1;
    else                 y = ywide[111:56] | {55'd0, |ywide[55:0]};
    diff  = {bm, 3'd0} - y;
  end

  // ---- next state ----
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = in_bad ? S_DONE : S_DEC;
      S_DEC:   if (dec_loaded && norm_done) state_next = S_ITER;
      S_ITER:  state_next = fin ? S_DONE : S_FRAC;
      S_FRAC:  if (norm_done) state_next = S_MULN;
      S_MULN:  if (mul_done) state_next = mul_ovf ? S_DONE : S_MULD;
      S_MULD: begin
        if (mul_done) begin
          if (mul_ovf)               state_next = S_DONE;
          else if (mul_res == 64'd0) state_next = S_REM;
          else                       state_next = S_CVTN;
        end
      end
      S_CVTN:  if (norm_done) state_next = S_CVTD;
      S_CVTD:  if (norm_done) state_next = (num == 64'd0) ? S_CMP : S_DIVQ;
      S_DIVQ:  if (div_done) state_next = vzero ? S_CMP : S_SUB;
      S_SUB:   state_next = S_SUBN;
      S_SUBN:  if (norm_done) state_next = S_CMP;
      S_CMP:   state_next = fin ? S_DONE : S_REM;
      S_REM:   state_next = fin ? S_DONE : S_RECIP;
      S_RECIP: if (div_done) state_next = S_ITER;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---- unit control and result selection ----
  always_comb begin
    norm_load  = 1'b0;
    norm_w_in  = dec_w;
    norm_e_in  = dec_e;
    mul_start  = 1'b0;
    mul_s      = s;
    mul_m      = c;
    mul_add    = a;
    div_start  = 1'b0;
    div_ma     = nm;
    div_ea     = ne;
    div_mb     = dm;
    div_eb     = de;
    fin        = 1'b0;
    fin_status = ST_INVALID;
    fin_num    = 64'd0;
    fin_den    = 64'd0;
    case (state)
      S_IDLE: begin
        if (start && in_bad) fin = 1'b1;
        // decode loads in the next cycle, from the captured value
      end
      S_DEC: begin
      end
      S_ITER: begin
        if (iter == IW'(MAX_ITERATIONS)) begin
          fin        = 1'b1;
          fin_status = ST_LIMIT;
        end else if (g_bad) begin
          fin = 1'b1;
        end else begin
          norm_load = 1'b1;
          norm_w_in = {frac_calc, 11'd0};
          norm_e_in = g_e;
        end
      end
      S_FRAC: begin
        if (norm_done) mul_start = 1'b1;
      end
      S_MULN: begin
        if (mul_done) begin
          if (mul_ovf) begin
            fin = 1'b1;
          end else begin
            mul_start = 1'b1;
            mul_m     = d;
            mul_add   = b;
          end
        end
      end
      S_MULD: begin
        if (mul_done) begin
          if (mul_ovf) begin
            fin = 1'b1;
          end else begin
            norm_load = 1'b1;
            norm_w_in = num;
            norm_e_in = 13'sd63;
          end
        end
      end
      S_CVTN: begin
        if (norm_done) begin
          norm_load = 1'b1;
          norm_w_in = den;
          norm_e_in = 13'sd63;
        end
      end
      S_CVTD: begin
        if (norm_done && (num != 64'd0)) begin
          div_start = 1'b1;
          div_mb    = nrnd.mant;
          div_eb    = nrnd_e;
        end
      end
      S_SUB: begin
        norm_load = 1'b1;
        norm_w_in = {diff, 8'd0};
        norm_e_in = be;
      end
      S_CMP: begin
        if (accept) begin
          fin = 1'b1;
          if (neg ? (num > 64'h8000_0000_0000_0000)
                  : (num > 64'h7FFF_FFFF_FFFF_FFFF)) begin
            fin_status = ST_INVALID;
          end else begin
            fin_status = ST_FOUND;
            fin_num    = neg ? (64'd0 - num) : num;
            fin_den    = den;
          end
        end
      end
      S_REM: begin
        if (rzero) begin
          fin = 1'b1;
        end else begin
          div_start = 1'b1;
          div_ma    = MANT_ONE;
          div_ea    = 13'sd0;
          div_mb    = rm;
          div_eb    = re;
        end
      end
      default: begin
      end
    endcase
    // value decode is loaded when S_DEC is entered
    if (state == S_IDLE && start && !in_bad) norm_load = 1'b0;
  end

  // the value register is captured on accept; dec_loaded marks the decode load as done
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tol        <= TOL_RESET;
      dec_loaded <= 1'b0;
    end else begin
      state      <= state_next;
      dec_loaded <= (state == S_DEC);
      if (cfg_we) tol <= tolerance_bits;
    end
  end

  logic dec_fire;
  assign dec_fire = (state == S_DEC) && !dec_loaded;

  // decode load is a separate path into the normalizer input mux
  logic        nl;
  logic [63:0] nw;
  exp_t        nexp;
  assign nl   = norm_load || dec_fire;
  assign nw   = dec_fire ? dec_w : norm_w_in;
  assign nexp = dec_fire ? dec_e : norm_e_in;

  rtfa_norm u_norm (
    .clk(clk), .load(nl), .w_in(nw), .e_in(nexp),
    .w(norm_w), .e(norm_e), .done(norm_done)
  );

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          vb  <= value_bits;
          neg <= value_bits[63];
        end
      end
      S_DEC: begin
        if (dec_loaded && norm_done) begin
          vzero  <= norm_w == 64'd0;
          vm     <= norm_w[63:11];
          ve     <= norm_e;
          g_zero <= norm_w == 64'd0;
          g_m    <= norm_w[63:11];
          g_e    <= norm_e;
          g_inf  <= 1'b0;
          iter   <= '0;
          a      <= 64'd0;
          b      <= 64'd1;
          c      <= 64'd1;
          d      <= 64'd0;
        end
      end
      S_ITER:  s <= s_calc;
      S_FRAC: begin
        if (norm_done) begin
          rm    <= norm_w[63:11];
          re    <= norm_e;
          rzero <= norm_w == 64'd0;
        end
      end
      S_MULN:  if (mul_done) num <= mul_res;
      S_MULD: begin
        if (mul_done) begin
          a   <= c;
          b   <= d;
          c   <= num;
          d   <= mul_res;
          den <= mul_res;
        end
      end
      S_CVTN: begin
        if (norm_done) begin
          nm <= nrnd.mant;
          ne <= nrnd_e;
        end
      end
      S_CVTD: begin
        if (norm_done) begin
          dm <= nrnd.mant;
          de <= nrnd_e;
          if (num == 64'd0) errb <= vb[62:0];
        end
      end
      S_DIVQ: begin
        if (div_done) begin
          qm <= div_mant;
          qe <= div_e;
          if (vzero) errb <= pack_pos(div_mant, div_e);
        end
      end
      S_SUBN: begin
        if (norm_done) errb <= (norm_w == 64'd0) ? 63'd0 : pack_pos(nrnd.mant, nrnd_e);
      end
      S_RECIP: begin
        if (div_done) begin
          g_inf  <= div_e > EXP_MAX;
          g_m    <= div_mant;
          g_e    <= div_e;
          g_zero <= 1'b0;
          iter   <= iter + IW'(1);
        end
      end
      default: begin
      end
    endcase
    if (fin) begin
      numerator   <= fin_num;
      denominator <= fin_den;
      status      <= fin_status;
    end
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  // ---- assertions ----
  a_fell_after_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_FOUND) |-> (numerator == 64'sd0 && denominator == 64'd0))
    else $error("failure result carries a fraction");

  a_found_den: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FOUND) |-> (denominator != 64'd0))
    else $error("found result with zero denominator");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_units_apart: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

endmodule
`default_nettype wire
